// ===== design/i2crts_pkg.sv =====
// Types and codes shared by the I2C register transfer sequencer.
`default_nettype none
package i2crts_pkg;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_ADDR_SENT = 3'd1,
		PH_WR_DATA   = 3'd2,
		PH_RSTART    = 3'd3,
		PH_DUMMY     = 3'd4,
		PH_RD_DATA   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		FN_START_WR = 2'd0,
		FN_START_RD = 2'd1,
		FN_XFER_DONE = 2'd2,
		FN_ARB_LOST = 2'd3
	} func_t;

	localparam logic [1:0] CMD_NONE   = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_RSTART = 2'd2;
	localparam logic [1:0] CMD_STOP   = 2'd3;

	localparam logic [1:0] ACK_KEEP = 2'd0;
	localparam logic [1:0] ACK_ACK  = 2'd1;
	localparam logic [1:0] ACK_NACK = 2'd2;

	localparam logic [1:0] FLT_NONE  = 2'd0;
	localparam logic [1:0] FLT_NOACK = 2'd1;
	localparam logic [1:0] FLT_BUSY  = 2'd2;
	localparam logic [1:0] FLT_ARB   = 2'd3;

	localparam logic [7:0] RW_READ_BIT = 8'h01;
	localparam logic [7:0] RW_ADDR_MASK = 8'hFE;

	typedef struct packed {
		logic       drive_valid;
		logic [7:0] drive_byte;
		logic [1:0] bus_command;
		logic       to_receive;
		logic [1:0] ack_control;
		logic       store_valid;
		logic [7:0] store_byte;
		logic [7:0] data_index;
		logic       done_res;
		logic [1:0] fault;
		logic       in_progress;
	} result_t;

endpackage
`default_nettype wire

// ===== design/i2c_register_transfer_sequencer.sv =====
// I2C master register transfer sequencer: one bus event in, one control result out.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------
//   input    | in_valid / in_stall   | func reg_addr byte_count bus_busy ack ...
//   output   | out_valid / out_stall | drive_* bus_command ... fault in_progress
//   config   | cfg_wr_en             | cfg_wr_data (device address)
//
// One beat per cycle while in_stall is low; the result of a beat is presented the cycle after it is taken.
// The state update and result logic sit between the input port and the result register.
// in_stall is raised only while a result is held and out_stall is high.
// Reset returns the sequencer to idle with no result pending.
`default_nettype none
module i2c_register_transfer_sequencer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [6:0] cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] func,
	input  wire logic [7:0] reg_addr,
	input  wire logic [7:0] byte_count,
	input  wire logic       bus_busy,
	input  wire logic       ack_received,
	input  wire logic [7:0] rx_byte,
	input  wire logic [7:0] tx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            drive_valid,
	output logic [7:0]      drive_byte,
	output logic [1:0]      bus_command,
	output logic            to_receive,
	output logic [1:0]      ack_control,
	output logic            store_valid,
	output logic [7:0]      store_byte,
	output logic [7:0]      data_index,
	output logic            done_res,
	output logic [1:0]      fault,
	output logic            in_progress
);
	import i2crts_pkg::*;

	logic [6:0] dev_addr_q, dev_addr_d;
	phase_t     phase_q, phase_d;
	logic       is_read_q, is_read_d;
	logic [7:0] idx_q, idx_d;
	logic [7:0] total_q, total_d;
	logic [7:0] treg_q, treg_d;
	logic [1:0] flt_q, flt_d;
	logic       busy_q, busy_d;
	logic       out_valid_q;
	result_t    res_q, res_d;
	logic       accept;
	logic [7:0] last_idx;
	logic [7:0] next_last_idx;
	logic [7:0] addr_w;
	logic [7:0] addr_r;
	func_t      fn;

	assign fn            = func_t'(func);
	assign in_stall      = out_valid_q & out_stall;
	assign accept        = in_valid & ~in_stall;
	assign last_idx      = total_q - 8'd1;
	assign next_last_idx = total_q - 8'd2;
	assign addr_w        = {dev_addr_q, 1'b0} & RW_ADDR_MASK;
	assign addr_r        = {dev_addr_q, 1'b0} | RW_READ_BIT;

	always_comb begin
		dev_addr_d = dev_addr_q;
		phase_d    = phase_q;
		is_read_d  = is_read_q;
		idx_d      = idx_q;
		total_d    = total_q;
		treg_d     = treg_q;
		flt_d      = flt_q;
		busy_d     = busy_q;
		if (cfg_wr_en) begin
			dev_addr_d = cfg_wr_data;
			phase_d    = PH_IDLE;
			is_read_d  = 1'b1;
			idx_d      = 8'd0;
			busy_d     = 1'b0;
		end else if (accept) begin
			case (fn)
				FN_START_WR, FN_START_RD: begin
					if (bus_busy) begin
						flt_d = FLT_BUSY;
					end else begin
						is_read_d = (fn == FN_START_RD);
						treg_d    = reg_addr;
						total_d   = (fn == FN_START_RD && byte_count == 8'd0) ? 8'd1 : byte_count;
						idx_d     = 8'd0;
						flt_d     = FLT_NONE;
						busy_d    = 1'b1;
						phase_d   = PH_ADDR_SENT;
					end
				end
				FN_ARB_LOST: begin
					flt_d = FLT_ARB;
				end
				default: begin
					case (phase_q)
						PH_ADDR_SENT: begin
							if (ack_received) begin
								phase_d = is_read_q ? PH_RSTART : PH_WR_DATA;
							end else begin
								flt_d   = FLT_NOACK;
								phase_d = PH_IDLE;
								busy_d  = 1'b0;
							end
						end
						PH_WR_DATA: begin
							if (idx_q == total_q) begin
								flt_d   = FLT_NONE;
								phase_d = PH_IDLE;
								busy_d  = 1'b0;
							end else if (ack_received) begin
								idx_d = idx_q + 8'd1;
							end else begin
								flt_d   = FLT_NOACK;
								phase_d = PH_IDLE;
								busy_d  = 1'b0;
							end
						end
						PH_RSTART: phase_d = PH_DUMMY;
						PH_DUMMY:  phase_d = PH_RD_DATA;
						PH_RD_DATA: begin
							if (idx_q == last_idx) begin
								flt_d   = FLT_NONE;
								phase_d = PH_IDLE;
								busy_d  = 1'b0;
							end
							idx_d = idx_q + 8'd1;
						end
						default: ;
					endcase
				end
			endcase
		end
	end

	always_comb begin
		res_d = '0;
		case (fn)
			FN_START_WR, FN_START_RD: begin
				if (bus_busy) begin
					res_d.done_res = 1'b1;
				end else begin
					res_d.drive_valid = 1'b1;
					res_d.drive_byte  = addr_w;
					res_d.bus_command = CMD_START;
				end
			end
			FN_ARB_LOST: ;
			default: begin
				case (phase_q)
					PH_ADDR_SENT: begin
						if (ack_received) begin
							res_d.drive_valid = 1'b1;
							res_d.drive_byte  = treg_q;
						end else begin
							res_d.bus_command = CMD_STOP;
							res_d.done_res    = 1'b1;
						end
					end
					PH_WR_DATA: begin
						if (idx_q != total_q && ack_received) begin
							res_d.drive_valid = 1'b1;
							res_d.drive_byte  = tx_byte;
							res_d.data_index  = idx_q;
						end else begin
							res_d.bus_command = CMD_STOP;
							res_d.done_res    = 1'b1;
						end
					end
					PH_RSTART: begin
						res_d.drive_valid = 1'b1;
						res_d.drive_byte  = addr_r;
						res_d.bus_command = CMD_RSTART;
					end
					PH_DUMMY: begin
						res_d.to_receive  = 1'b1;
						res_d.ack_control = (idx_q == last_idx) ? ACK_NACK : ACK_ACK;
					end
					PH_RD_DATA: begin
						if (idx_q == last_idx) begin
							res_d.bus_command = CMD_STOP;
							res_d.done_res    = 1'b1;
						end else if (idx_q == next_last_idx) begin
							res_d.ack_control = ACK_NACK;
						end
						res_d.store_valid = 1'b1;
						res_d.store_byte  = rx_byte;
						res_d.data_index  = idx_q;
					end
					default: ;
				endcase
			end
		endcase
		res_d.fault       = flt_d;
		res_d.in_progress = busy_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q  <= '0;
			phase_q     <= PH_IDLE;
			is_read_q   <= 1'b1;
			idx_q       <= '0;
			total_q     <= '0;
			treg_q      <= '0;
			flt_q       <= FLT_NONE;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			dev_addr_q <= dev_addr_d;
			phase_q    <= phase_d;
			is_read_q  <= is_read_d;
			idx_q      <= idx_d;
			total_q    <= total_d;
			treg_q     <= treg_d;
			flt_q      <= flt_d;
			busy_q     <= busy_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_valid = res_q.drive_valid;
	assign drive_byte  = res_q.drive_byte;
	assign bus_command = res_q.bus_command;
	assign to_receive  = res_q.to_receive;
	assign ack_control = res_q.ack_control;
	assign store_valid = res_q.store_valid;
	assign store_byte  = res_q.store_byte;
	assign data_index  = res_q.data_index;
	assign done_res    = res_q.done_res;
	assign fault       = res_q.fault;
	assign in_progress = res_q.in_progress;

`ifndef SYNTHESIS
	a_idle_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> !busy_q)
		else $error("idle phase with busy flag set");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted beat produced no result");

	a_store_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.store_valid |-> !res_q.drive_valid && !res_q.to_receive)
		else $error("store and drive in one result");

	a_start_addr_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.bus_command == CMD_START |->
			!res_q.drive_byte[0] && res_q.in_progress)
		else $error("start without write address or busy flag");

	a_rstart_addr_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.bus_command == CMD_RSTART |-> res_q.drive_byte[0])
		else $error("repeated start without read address");

	a_stop_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.bus_command == CMD_STOP |-> res_q.done_res && !res_q.in_progress)
		else $error("stop without completion");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the I2C register transfer sequencer.
`timescale 1ns / 1ps
module testbench;
	import i2crts_pkg::*;

	typedef struct packed {
		func_t      func;
		logic [7:0] reg_addr;
		logic [7:0] byte_count;
		logic       bus_busy;
		logic       ack_received;
		logic [7:0] rx_byte;
		logic [7:0] tx_byte;
	} bus_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [6:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	func_t func = FN_START_WR;
	logic [7:0] reg_addr = '0;
	logic [7:0] byte_count = '0;
	logic bus_busy = 1'b0;
	logic ack_received = 1'b0;
	logic [7:0] rx_byte = '0;
	logic [7:0] tx_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic drive_valid;
	logic [7:0] drive_byte;
	logic [1:0] bus_command;
	logic to_receive;
	logic [1:0] ack_control;
	logic store_valid;
	logic [7:0] store_byte;
	logic [7:0] data_index;
	logic done_res;
	logic [1:0] fault;
	logic in_progress;

	i2c_register_transfer_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .reg_addr(reg_addr), .byte_count(byte_count),
		.bus_busy(bus_busy), .ack_received(ack_received),
		.rx_byte(rx_byte), .tx_byte(tx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.drive_valid(drive_valid), .drive_byte(drive_byte),
		.bus_command(bus_command), .to_receive(to_receive),
		.ack_control(ack_control), .store_valid(store_valid),
		.store_byte(store_byte), .data_index(data_index),
		.done_res(done_res), .fault(fault), .in_progress(in_progress)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sequencer state mirror
	logic [6:0] dev_addr = '0;
	phase_t seq_phase = PH_IDLE;
	logic rd_mode = 1'b1;
	logic [7:0] byte_idx = '0;
	logic [7:0] byte_tot = '0;
	logic [7:0] tgt_reg = '0;
	logic [1:0] last_flt = FLT_NONE;
	logic busy_flag = 1'b0;

	bus_event_t bus_events[$];
	result_t expected_controls[$];
	int errors = 0;
	int queued = 0;
	int taken = 0;
	int checked = 0;
	int transfers = 0;
	int settings = 0;
	int unsigned cyc = 0;
	bit in_took = 1'b0;
	bit big_done = 1'b0;

	function automatic result_t sequence_event(bus_event_t ev);
		result_t r;
		logic [7:0] last;
		bit stop;
		logic [1:0] stop_flt;
		r = '0;
		last = byte_tot - 8'd1;
		stop = 1'b0;
		stop_flt = FLT_NONE;
		case (ev.func)
			FN_START_WR, FN_START_RD: begin
				if (ev.bus_busy) begin
					last_flt = FLT_BUSY;
					r.done_res = 1'b1;
				end else begin
					rd_mode = (ev.func == FN_START_RD);
					tgt_reg = ev.reg_addr;
					byte_tot = (rd_mode && ev.byte_count == 8'd0) ? 8'd1 : ev.byte_count;
					byte_idx = '0;
					last_flt = FLT_NONE;
					busy_flag = 1'b1;
					seq_phase = PH_ADDR_SENT;
					r.drive_valid = 1'b1;
					r.drive_byte = {dev_addr, 1'b0} & RW_ADDR_MASK;
					r.bus_command = CMD_START;
				end
			end
			FN_ARB_LOST: last_flt = FLT_ARB;
			default: begin
				case (seq_phase)
					PH_ADDR_SENT: begin
						if (ev.ack_received) begin
							r.drive_valid = 1'b1;
							r.drive_byte = tgt_reg;
							seq_phase = rd_mode ? PH_RSTART : PH_WR_DATA;
						end else begin
							stop = 1'b1;
							stop_flt = FLT_NOACK;
						end
					end
					PH_WR_DATA: begin
						if (byte_idx == byte_tot) begin
							stop = 1'b1;
						end else if (ev.ack_received) begin
							r.drive_valid = 1'b1;
							r.drive_byte = ev.tx_byte;
							r.data_index = byte_idx;
							byte_idx = byte_idx + 8'd1;
						end else begin
							stop = 1'b1;
							stop_flt = FLT_NOACK;
						end
					end
					PH_RSTART: begin
						r.drive_valid = 1'b1;
						r.drive_byte = {dev_addr, 1'b0} | RW_READ_BIT;
						r.bus_command = CMD_RSTART;
						seq_phase = PH_DUMMY;
					end
					PH_DUMMY: begin
						r.to_receive = 1'b1;
						r.ack_control = (byte_idx == last) ? ACK_NACK : ACK_ACK;
						seq_phase = PH_RD_DATA;
					end
					PH_RD_DATA: begin
						if (byte_idx == last)
							stop = 1'b1;
						else if (byte_idx == byte_tot - 8'd2)
							r.ack_control = ACK_NACK;
						r.store_valid = 1'b1;
						r.store_byte = ev.rx_byte;
						r.data_index = byte_idx;
						byte_idx = byte_idx + 8'd1;
					end
					default: ;
				endcase
			end
		endcase
		if (stop) begin
			r.bus_command = CMD_STOP;
			r.done_res = 1'b1;
			last_flt = stop_flt;
			seq_phase = PH_IDLE;
			busy_flag = 1'b0;
		end
		r.fault = last_flt;
		r.in_progress = busy_flag;
		return r;
	endfunction

	task automatic note_mismatch(string what, int got, int want);
		errors++;
		$display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	task automatic check_result(result_t got, result_t want);
		if (got.drive_valid !== want.drive_valid)
			note_mismatch("drive_valid", int'(got.drive_valid), int'(want.drive_valid));
		if (got.drive_byte !== want.drive_byte)
			note_mismatch("drive_byte", int'(got.drive_byte), int'(want.drive_byte));
		if (got.bus_command !== want.bus_command)
			note_mismatch("bus_command", int'(got.bus_command), int'(want.bus_command));
		if (got.to_receive !== want.to_receive)
			note_mismatch("to_receive", int'(got.to_receive), int'(want.to_receive));
		if (got.ack_control !== want.ack_control)
			note_mismatch("ack_control", int'(got.ack_control), int'(want.ack_control));
		if (got.store_valid !== want.store_valid)
			note_mismatch("store_valid", int'(got.store_valid), int'(want.store_valid));
		if (got.store_byte !== want.store_byte)
			note_mismatch("store_byte", int'(got.store_byte), int'(want.store_byte));
		if (got.data_index !== want.data_index)
			note_mismatch("data_index", int'(got.data_index), int'(want.data_index));
		if (got.done_res !== want.done_res)
			note_mismatch("done_res", int'(got.done_res), int'(want.done_res));
		if (got.fault !== want.fault)
			note_mismatch("fault", int'(got.fault), int'(want.fault));
		if (got.in_progress !== want.in_progress)
			note_mismatch("in_progress", int'(got.in_progress), int'(want.in_progress));
	endtask

	// input acceptance and output checking
	always @(posedge clk) begin
		result_t got;
		cyc++;
		in_took = arst_n && in_valid && !in_stall;
		if (in_took) begin
			expected_controls.push_back(sequence_event({func, reg_addr, byte_count, bus_busy,
				ack_received, rx_byte, tx_byte}));
			taken++;
		end
		if (arst_n && out_valid && !out_stall) begin
			got = {drive_valid, drive_byte, bus_command, to_receive, ack_control, store_valid,
				store_byte, data_index, done_res, fault, in_progress};
			if (expected_controls.size() == 0) begin
				note_mismatch("unexpected result beat", 1, 0);
			end else begin
				check_result(got, expected_controls.pop_front());
				checked++;
			end
		end
	end

	// driver and receiver stall
	always @(negedge clk) begin
		bus_event_t ev;
		bit calm;
		calm = (cyc >= 400) && (cyc < 520);
		if (arst_n) begin
			if (!in_valid || in_took) begin
				if (bus_events.size() != 0 && (calm || $urandom_range(0, 99) >= 27)) begin
					ev = bus_events.pop_front();
					func <= ev.func;
					reg_addr <= ev.reg_addr;
					byte_count <= ev.byte_count;
					bus_busy <= ev.bus_busy;
					ack_received <= ev.ack_received;
					rx_byte <= ev.rx_byte;
					tx_byte <= ev.tx_byte;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= !calm && ($urandom_range(0, 99) < 27);
		end
	end

	task automatic add_event(func_t f, logic [7:0] ra, logic [7:0] bc, logic bb, logic ak,
		logic [7:0] rx, logic [7:0] tx);
		bus_events.push_back({f, ra, bc, bb, ak, rx, tx});
		queued++;
	endtask

	task automatic add_transfer(bit rd, int cnt);
		int steps;
		bit refuse;
		bit ack;
		refuse = ($urandom_range(0, 14) == 0);
		transfers++;
		add_event(rd ? FN_START_RD : FN_START_WR, 8'($urandom_range(0, 255)), cnt[7:0], refuse,
			1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		if (!refuse) begin
			steps = rd ? ((cnt == 0) ? 1 : cnt) + 3 : cnt + 2;
			for (int i = 0; i < steps; i++) begin
				ack = ($urandom_range(0, 29) != 0);
				if ($urandom_range(0, 39) == 0)
					add_event(FN_ARB_LOST, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				add_event(FN_XFER_DONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), ack, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
				if (!ack)
					break;
			end
		end
	endtask

	task automatic drain();
		while (bus_events.size() != 0 || taken != queued || expected_controls.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_address(logic [6:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		dev_addr = v;
		seq_phase = PH_IDLE;
		rd_mode = 1'b1;
		byte_idx = '0;
		busy_flag = 1'b0;
		settings++;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic add_random(int target);
		int mark;
		int cnt;
		func_t f;
		mark = queued;
		while (queued - mark < target) begin
			if ($urandom_range(0, 99) < 80) begin
				cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
				if (!big_done && $urandom_range(0, 30) == 0) begin
					cnt = 255;
					big_done = 1'b1;
				end
				add_transfer(1'($urandom_range(0, 1)), cnt);
			end else begin
				f = func_t'($urandom_range(0, 3));
				add_event(f, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				if (f == FN_XFER_DONE)
					mark++;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// idle events, busy refusal, zero sizes, nack, abandon, read nack ahead of last byte
		add_event(FN_XFER_DONE, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF, 8'hFF);
		add_event(FN_ARB_LOST, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
		add_event(FN_START_WR, 8'h12, 8'h03, 1'b1, 1'b0, 8'h00, 8'h00);
		add_event(FN_START_WR, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
		add_event(FN_XFER_DONE, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00);
		add_event(FN_XFER_DONE, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00);
		add_event(FN_START_RD, 8'hFF, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00);
		add_event(FN_XFER_DONE, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00);
		add_event(FN_XFER_DONE, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
		add_event(FN_XFER_DONE, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00);
		add_event(FN_XFER_DONE, 8'h00, 8'h00, 1'b0, 1'b1, 8'hFF, 8'h00);
		add_event(FN_START_WR, 8'h3C, 8'h01, 1'b0, 1'b1, 8'h00, 8'h00);
		add_event(FN_XFER_DONE, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
		add_event(FN_START_RD, 8'h80, 8'hFF, 1'b0, 1'b1, 8'h00, 8'h00);
		add_event(FN_XFER_DONE, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00);
		add_event(FN_ARB_LOST, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF, 8'hFF);
		add_event(FN_START_WR, 8'hA5, 8'h02, 1'b0, 1'b1, 8'h00, 8'h00);
		add_event(FN_XFER_DONE, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00);
		add_event(FN_XFER_DONE, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 8'hFF);
		add_event(FN_XFER_DONE, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h5A);
		add_event(FN_START_RD, 8'h5A, 8'h02, 1'b0, 1'b0, 8'h00, 8'h00);
		add_event(FN_XFER_DONE, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00);
		add_event(FN_XFER_DONE, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00);
		add_event(FN_XFER_DONE, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00);
		add_event(FN_XFER_DONE, 8'h00, 8'h00, 1'b0, 1'b1, 8'hC3, 8'h00);
		add_event(FN_XFER_DONE, 8'h00, 8'h00, 1'b0, 1'b1, 8'h3C, 8'h00);
		drain();

		write_address(7'h7F);
		add_random(135);
		drain();
		write_address(7'h00);
		add_random(135);
		drain();
		write_address(7'($urandom_range(1, 126)));
		add_random(135);
		drain();
		write_address(7'h2A);
		add_random(135);
		drain();
		repeat (5) @(posedge clk);

		$display("Covered %0d input beats, %0d transfers, %0d result beats checked",
			taken, transfers, checked);
		$display("across %0d device address writes, long read included: %0d", settings,
			big_done);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d result beats outstanding", expected_controls.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
